[rtl/pasm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pasm_pkg
// Shared sizes, request codes and pipeline types of the polynomial
// add / subtract / multiply unit.
// ----------------------------------------------------------------------------
package pasm_pkg;

  localparam int MAX_TERMS  = 16;
  localparam int COEF_WIDTH = 32;
  localparam int ACC_TERMS  = 2 * MAX_TERMS - 1;

  localparam int IDX_W = $clog2(MAX_TERMS);
  localparam int CNT_W = $clog2(MAX_TERMS + 1);
  localparam int LEN_W = $clog2(ACC_TERMS + 1);
  localparam int POW_W = 5;

  localparam logic [1:0] REQ_LOAD_A = 2'd0;
  localparam logic [1:0] REQ_LOAD_B = 2'd1;
  localparam logic [1:0] REQ_START  = 2'd2;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;

  typedef struct packed {
    logic is_mul;
    logic is_sub;
  } op_ctl_t;

  typedef struct packed {
    logic valid;
    logic use_a;
    logic use_b;
    logic first;
  } term_tag_t;

endpackage

[rtl/pasm_mac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pasm_mac
// Term pipeline: masks the operands read from the stores, forms a sum,
// difference or product, and accumulates the terms of one coefficient.
// ----------------------------------------------------------------------------
module pasm_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  pasm_pkg::op_ctl_t                   op,
  input  pasm_pkg::term_tag_t                 issue_tag,
  input  logic [pasm_pkg::COEF_WIDTH-1:0]     rd_a,
  input  logic [pasm_pkg::COEF_WIDTH-1:0]     rd_b,
  output logic [pasm_pkg::COEF_WIDTH-1:0]     acc,
  output logic                                busy
);
  import pasm_pkg::*;

  term_tag_t             tag_rd;
  term_tag_t             tag_term;
  logic [COEF_WIDTH-1:0] opa;
  logic [COEF_WIDTH-1:0] opb;
  logic [COEF_WIDTH-1:0] term;

  // missing coefficients of the shorter operand read as zero
  assign opa  = tag_rd.use_a ? rd_a : '0;
  assign opb  = tag_rd.use_b ? rd_b : '0;
  assign busy = tag_rd.valid | tag_term.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_rd   <= '0;
      tag_term <= '0;
    end else begin
      tag_rd   <= issue_tag;
      tag_term <= tag_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (op.is_mul) begin
      term <= opa * opb;
    end else if (op.is_sub) begin
      term <= opa - opb;
    end else begin
      term <= opa + opb;
    end
    if (tag_term.valid) begin
      acc <= tag_term.first ? term : acc + term;
    end
  end

endmodule

[rtl/polynomial_add_sub_multiply_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_add_sub_multiply_unit
// Two coefficient stores and a term sequencer for polynomial add, subtract
// and multiply.
// ----------------------------------------------------------------------------
// Load items are accepted back to back while the unit is idle; each appends a
// coefficient to one of two 16-entry stores, and loads into a full store are
// dropped. A start item stalls the request channel until its whole result
// has been handed to the output register. Every result coefficient is built
// by a sequencer that reads one term per cycle from the two store memories
// through a three-stage read / combine / accumulate pipeline. Add and
// subtract have one term per coefficient; multiply has one term for each pair
// of operand coefficients whose powers add up to the result power. Both
// stores are empty after every start; a start with nothing to emit returns
// to idle at once.
// ----------------------------------------------------------------------------
module polynomial_add_sub_multiply_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   req_valid,
  output logic                                   req_stall,
  input  logic [1:0]                             req_type,
  input  logic signed [pasm_pkg::COEF_WIDTH-1:0] coef_value,
  input  logic [1:0]                             op_select,
  output logic                                   res_valid,
  input  logic                                   res_stall,
  output logic signed [pasm_pkg::COEF_WIDTH-1:0] result_coef,
  output logic [pasm_pkg::POW_W-1:0]             result_power,
  output logic                                   last_flag
);
  import pasm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_ISSUE  = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t                state;
  logic [CNT_W-1:0]      first_count;
  logic [CNT_W-1:0]      second_count;
  logic [CNT_W-1:0]      na;
  logic [CNT_W-1:0]      nb;
  op_ctl_t               op;
  op_ctl_t               start_op;
  logic [LEN_W-1:0]      len;
  logic [LEN_W-1:0]      start_len;
  logic [CNT_W:0]        sum_len;
  logic [LEN_W-1:0]      k;
  logic [LEN_W-1:0]      k_next;
  logic [LEN_W-1:0]      ti;
  logic [LEN_W-1:0]      ti_hi;
  logic [LEN_W-1:0]      kb;
  logic                  first_q;
  logic [COEF_WIDTH-1:0] first_mem  [MAX_TERMS];
  logic [COEF_WIDTH-1:0] second_mem [MAX_TERMS];
  logic [COEF_WIDTH-1:0] rd_a;
  logic [COEF_WIDTH-1:0] rd_b;
  logic [IDX_W-1:0]      addr_a;
  logic [IDX_W-1:0]      addr_b;
  term_tag_t             issue_tag;
  logic [COEF_WIDTH-1:0] acc;
  logic                  busy;
  logic                  req_take;
  logic                  res_free;
  logic                  res_push;
  logic                  is_last;

  // lowest first-operand index contributing to coefficient kk
  function automatic logic [LEN_W-1:0] term_lo(input logic [LEN_W-1:0] kk,
                                               input logic [CNT_W-1:0] n2,
                                               input logic mul);
    logic [LEN_W-1:0] n2w;
    n2w = LEN_W'(n2);
    if (!mul) return kk;
    if (kk >= n2w) return kk - n2w + LEN_W'(1);
    return '0;
  endfunction

  // highest first-operand index contributing to coefficient kk
  function automatic logic [LEN_W-1:0] term_hi(input logic [LEN_W-1:0] kk,
                                               input logic [CNT_W-1:0] n1,
                                               input logic mul);
    logic [LEN_W-1:0] n1w;
    n1w = LEN_W'(n1);
    if (!mul) return kk;
    if (kk < n1w) return kk;
    return n1w - LEN_W'(1);
  endfunction

  assign req_stall = (state != ST_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign res_free  = !res_valid || !res_stall;
  assign res_push  = (state == ST_FINISH) && !busy && res_free;
  assign is_last   = (k == len - LEN_W'(1));
  assign k_next    = k + LEN_W'(1);

  always_comb begin
    start_op.is_mul = (op_select != OP_ADD) && (op_select != OP_SUB);
    start_op.is_sub = (op_select == OP_SUB);
    sum_len = {1'b0, first_count} + {1'b0, second_count} - (CNT_W + 1)'(1);
    if (start_op.is_mul) begin
      start_len = (first_count != '0 && second_count != '0) ? LEN_W'(sum_len) : '0;
    end else begin
      start_len = (first_count > second_count) ? LEN_W'(first_count)
                                               : LEN_W'(second_count);
    end
  end

  always_comb begin
    kb              = op.is_mul ? k - ti : ti;
    addr_a          = ti[IDX_W-1:0];
    addr_b          = kb[IDX_W-1:0];
    issue_tag.valid = (state == ST_ISSUE);
    issue_tag.use_a = op.is_mul || (ti < LEN_W'(na));
    issue_tag.use_b = op.is_mul || (ti < LEN_W'(nb));
    issue_tag.first = first_q;
  end

  // coefficient stores: append on load, one registered read port each
  always_ff @(posedge clk) begin
    if (req_take && req_type == REQ_LOAD_A && first_count < CNT_W'(MAX_TERMS)) begin
      first_mem[first_count[IDX_W-1:0]] <= coef_value;
    end
    if (req_take && req_type == REQ_LOAD_B && second_count < CNT_W'(MAX_TERMS)) begin
      second_mem[second_count[IDX_W-1:0]] <= coef_value;
    end
    rd_a <= first_mem[addr_a];
    rd_b <= second_mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      first_count  <= '0;
      second_count <= '0;
      res_valid    <= 1'b0;
      first_q      <= 1'b0;
    end else begin
      // drop the output slot after its transfer unless a new one refills it
      if (res_valid && !res_stall && !res_push) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_take) begin
            priority case (req_type)
              REQ_LOAD_A: begin
                if (first_count < CNT_W'(MAX_TERMS)) first_count <= first_count + CNT_W'(1);
              end
              REQ_LOAD_B: begin
                if (second_count < CNT_W'(MAX_TERMS)) second_count <= second_count + CNT_W'(1);
              end
              REQ_START: begin
                na           <= first_count;
                nb           <= second_count;
                op           <= start_op;
                len          <= start_len;
                k            <= '0;
                ti           <= '0;
                ti_hi        <= '0;
                first_q      <= 1'b1;
                first_count  <= '0;
                second_count <= '0;
                state        <= (start_len != '0) ? ST_ISSUE : ST_IDLE;
              end
              default: ;
            endcase
          end
        end
        ST_ISSUE: begin
          first_q <= 1'b0;
          if (ti == ti_hi) begin
            state <= ST_FINISH;
          end else begin
            ti <= ti + LEN_W'(1);
          end
        end
        ST_FINISH: begin
          // hold until the pipeline has drained and the output slot is free
          if (res_push) begin
            res_valid    <= 1'b1;
            result_coef  <= acc;
            result_power <= POW_W'(k);
            last_flag    <= is_last;
            if (is_last) begin
              state <= ST_IDLE;
            end else begin
              k       <= k_next;
              ti      <= term_lo(k_next, nb, op.is_mul);
              ti_hi   <= term_hi(k_next, na, op.is_mul);
              first_q <= 1'b1;
              state   <= ST_ISSUE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  pasm_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .issue_tag (issue_tag),
    .rd_a      (rd_a),
    .rd_b      (rd_b),
    .acc       (acc),
    .busy      (busy)
  );

endmodule

[rtl/pasm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pasm_checker
// Port-level checks of the polynomial unit, bound to the top level.
// ----------------------------------------------------------------------------
module pasm_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   req_valid,
  input logic                                   req_stall,
  input logic [1:0]                             req_type,
  input logic signed [pasm_pkg::COEF_WIDTH-1:0] coef_value,
  input logic [1:0]                             op_select,
  input logic                                   res_valid,
  input logic                                   res_stall,
  input logic signed [pasm_pkg::COEF_WIDTH-1:0] result_coef,
  input logic [pasm_pkg::POW_W-1:0]             result_power,
  input logic                                   last_flag
);
  import pasm_pkg::*;

  logic [POW_W-1:0] exp_power;

  // expected power of the next coefficient: restart after a marked transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_power <= '0;
    end else if (res_valid && !res_stall) begin
      exp_power <= last_flag ? '0 : result_power + POW_W'(1);
    end
  end

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(result_coef)
      && $stable(result_power) && $stable(last_flag))
    else $error("result changed while stalled");

  a_power_order: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> result_power == exp_power)
    else $error("result power out of sequence");

  a_power_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && !last_flag |-> result_power < POW_W'(ACC_TERMS - 1))
    else $error("unmarked coefficient at highest power");

  a_load_single: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req_type != REQ_START |=> !req_stall)
    else $error("load transfer stalled the request channel");

endmodule

bind polynomial_add_sub_multiply_unit pasm_checker u_pasm_checker (.*);

[tb/sv/tb_polynomial_add_sub_multiply_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polynomial_add_sub_multiply_unit
// Self-checking bench for the polynomial add / subtract / multiply unit.
// ----------------------------------------------------------------------------
// Coefficient loads and start requests go in through the request channel. A
// scoreboard keeps its own copy of both coefficient stores and, on each
// accepted start, computes the sum, difference or product terms it expects.
// Every result transfer is checked against the oldest expected term. A short
// directed part covers the corner cases. Random load/start sequences follow,
// with idle bursts on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_polynomial_add_sub_multiply_unit;
  import pasm_pkg::*;

  localparam logic [1:0] OP_MUL       = 2'd2;
  localparam logic [1:0] OP_MUL_ALIAS = 2'd3;  // unused code, behaves as multiply
  localparam logic [1:0] REQ_IGNORED  = 2'd3;  // unused request code

  localparam int TARGET_ITEMS = 260;
  localparam int QUIET_ITEMS  = 40;
  localparam int LONG_HOLD    = 300;
  localparam int HOLD_AFTER   = 40;
  localparam int DRAIN_CYCLES = 20;
  localparam int TIMEOUT_NS   = 20_000_000;

  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] coef;
    logic [POW_W-1:0]             power;
    logic                         last;
  } coef_term_t;

  class poly_scoreboard;
    logic [COEF_WIDTH-1:0] first_terms [MAX_TERMS];
    logic [COEF_WIDTH-1:0] second_terms [MAX_TERMS];
    int first_len;
    int second_len;
    coef_term_t due_terms [$];
    int checked;
    int errors;
    int longest;

    function void predict_terms(logic [1:0] kind, logic [COEF_WIDTH-1:0] value,
                                logic [1:0] op);
      logic [COEF_WIDTH-1:0] acc [ACC_TERMS];
      logic [COEF_WIDTH-1:0] a;
      logic [COEF_WIDTH-1:0] b;
      coef_term_t term;
      int len;
      len = 0;
      case (kind)
        REQ_LOAD_A: begin
          if (first_len < MAX_TERMS) begin
            first_terms[first_len] = value;
            first_len++;
          end
        end
        REQ_LOAD_B: begin
          if (second_len < MAX_TERMS) begin
            second_terms[second_len] = value;
            second_len++;
          end
        end
        REQ_START: begin
          if (op == OP_ADD || op == OP_SUB) begin
            // zero-extend the shorter operand
            len = (first_len > second_len) ? first_len : second_len;
            for (int i = 0; i < len; i++) begin
              a = (i < first_len) ? first_terms[i] : '0;
              b = (i < second_len) ? second_terms[i] : '0;
              term.coef  = (op == OP_ADD) ? a + b : a - b;
              term.power = POW_W'(i);
              term.last  = (i == len - 1);
              due_terms.push_back(term);
            end
          end else if (first_len != 0 && second_len != 0) begin
            len = first_len + second_len - 1;
            for (int k = 0; k < ACC_TERMS; k++) acc[k] = '0;
            for (int i = 0; i < first_len; i++)
              for (int j = 0; j < second_len; j++)
                acc[i + j] = acc[i + j] + first_terms[i] * second_terms[j];
            for (int k = 0; k < len; k++) begin
              term.coef  = acc[k];
              term.power = POW_W'(k);
              term.last  = (k == len - 1);
              due_terms.push_back(term);
            end
          end
          if (len > longest) longest = len;
          first_len  = 0;
          second_len = 0;
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [COEF_WIDTH-1:0] coef, logic [POW_W-1:0] power,
                               logic last);
      coef_term_t want;
      if (due_terms.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: unexpected result coef %h power %0d last %0d",
                   coef, power, last);
        return;
      end
      want = due_terms.pop_front();
      if (want.coef !== coef || want.power !== power || want.last !== last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected coef %h power %0d last %0d, got coef %h power %0d last %0d",
                   want.coef, want.power, want.last, coef, power, last);
      end else begin
        checked++;
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         req_valid;
  logic                         req_stall;
  logic [1:0]                   req_type;
  logic signed [COEF_WIDTH-1:0] coef_value;
  logic [1:0]                   op_select;
  logic                         res_valid;
  logic                         res_stall;
  logic signed [COEF_WIDTH-1:0] result_coef;
  logic [POW_W-1:0]             result_power;
  logic                         last_flag;

  poly_scoreboard sb = new();
  int  gap_level;
  bit  quiet_tail;
  int  items_sent;
  int  starts_sent;
  int  noise_sent;

  polynomial_add_sub_multiply_unit dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_type     (req_type),
    .coef_value   (coef_value),
    .op_select    (op_select),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .result_coef  (result_coef),
    .result_power (result_power),
    .last_flag    (last_flag)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [COEF_WIDTH-1:0] pick_coef();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 32'h7FFF_FFFF;
    if (sel == 1) return 32'h8000_0000;
    if (sel == 2) return '1;
    if (sel < 6) return $urandom_range(0, 16) - 8;
    return $urandom();
  endfunction

  // Offer one request and hold it until the transfer happens.
  task automatic send_request(logic [1:0] kind, logic [COEF_WIDTH-1:0] value,
                              logic [1:0] op);
    if (!quiet_tail && gap_level != 0 && $urandom_range(0, 7) < gap_level) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    req_valid  <= 1'b1;
    req_type   <= kind;
    coef_value <= value;
    op_select  <= op;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.predict_terms(kind, value, op);
    if (kind == REQ_IGNORED) noise_sent++;
    else items_sent++;
    if (kind == REQ_START) starts_sent++;
  endtask

  // Load both operands in a random interleaving, then start.
  task automatic run_poly_op(int len_a, int len_b, logic [1:0] op);
    int left_a;
    int left_b;
    left_a = len_a;
    left_b = len_b;
    while (left_a + left_b > 0) begin
      if (left_b == 0 || (left_a > 0 && $urandom_range(0, 1) == 1)) begin
        send_request(REQ_LOAD_A, pick_coef(), 2'($urandom_range(0, 3)));
        left_a--;
      end else begin
        send_request(REQ_LOAD_B, pick_coef(), 2'($urandom_range(0, 3)));
        left_b--;
      end
      if ($urandom_range(0, 15) == 0)
        send_request(REQ_IGNORED, $urandom(), 2'($urandom_range(0, 3)));
    end
    send_request(REQ_START, $urandom(), op);
  endtask

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall)
      sb.check_result(result_coef, result_power, last_flag);
  end

  // Result side: random stall bursts, plus one long hold-off.
  initial begin : result_side
    int  stall_level;
    int  cycles;
    bit  held;
    stall_level = 0;
    cycles      = 0;
    held        = 1'b0;
    res_stall  <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles % 128 == 0) stall_level = $urandom_range(0, 3);
      if (!held && sb.checked >= HOLD_AFTER) begin
        held = 1'b1;
        res_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (!quiet_tail && stall_level != 0 && $urandom_range(0, 7) < stall_level) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      res_stall <= 1'b0;
    end
  end

  initial begin : request_side
    int len_a;
    int len_b;
    int shape;
    rst        <= 1'b1;
    req_valid  <= 1'b0;
    req_type   <= REQ_LOAD_A;
    coef_value <= '0;
    op_select  <= OP_ADD;
    gap_level   = $urandom_range(0, 3);
    quiet_tail  = 1'b0;
    items_sent  = 0;
    starts_sent = 0;
    noise_sent  = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty operands: nothing comes back, stores still cleared
    send_request(REQ_START, '0, OP_ADD);
    send_request(REQ_LOAD_B, 32'd3, OP_SUB);
    send_request(REQ_START, '1, OP_MUL);
    // wrapping add, ignored request code in between
    send_request(REQ_LOAD_A, 32'h7FFF_FFFF, OP_MUL_ALIAS);
    send_request(REQ_LOAD_A, 32'h8000_0000, OP_MUL);
    send_request(REQ_LOAD_B, '1, OP_ADD);
    send_request(REQ_IGNORED, '1, OP_MUL_ALIAS);
    send_request(REQ_START, 32'h5555_5555, OP_ADD);
    // subtract with the second operand longer
    send_request(REQ_LOAD_A, 32'h8000_0000, OP_ADD);
    send_request(REQ_LOAD_B, 32'd1, OP_ADD);
    send_request(REQ_LOAD_B, '1, OP_SUB);
    send_request(REQ_START, 32'hAAAA_AAAA, OP_SUB);
    // multiply through the unused operation code
    send_request(REQ_LOAD_A, '1, OP_ADD);
    send_request(REQ_LOAD_A, 32'h7FFF_FFFF, OP_SUB);
    send_request(REQ_LOAD_B, 32'h8000_0000, OP_MUL);
    send_request(REQ_START, '0, OP_MUL_ALIAS);
    // subtract with the second store empty
    send_request(REQ_LOAD_A, 32'h1234_5678, OP_MUL);
    send_request(REQ_START, '0, OP_SUB);

    // both stores full, extra loads into the first dropped
    run_poly_op(MAX_TERMS + 2, MAX_TERMS, OP_MUL);

    while (items_sent < TARGET_ITEMS) begin
      if (items_sent > TARGET_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
      gap_level = $urandom_range(0, 3);
      shape = $urandom_range(0, 15);
      if (shape == 0) begin
        len_a = $urandom_range(MAX_TERMS - 2, MAX_TERMS + 3);
        len_b = $urandom_range(MAX_TERMS - 2, MAX_TERMS + 3);
      end else if (shape == 1) begin
        len_a = $urandom_range(0, 1) ? 0 : $urandom_range(1, 4);
        len_b = (len_a == 0) ? $urandom_range(0, 4) : 0;
      end else begin
        len_a = $urandom_range(1, 5);
        len_b = $urandom_range(1, 5);
      end
      run_poly_op(len_a, len_b, 2'($urandom_range(0, 3)));
    end
    req_valid <= 1'b0;

    while (sb.due_terms.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d requests, %0d starts, %0d unused-code requests",
             items_sent, starts_sent, noise_sent);
    $display("summary: %0d coefficients matched, longest result %0d terms, %0d errors",
             sb.checked, sb.longest, sb.errors);
    if (sb.errors == 0 && sb.due_terms.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #TIMEOUT_NS;
    $display("tb: failure");
    $finish;
  end

endmodule

[files.f]
rtl/pasm_pkg.sv
rtl/pasm_mac.sv
rtl/polynomial_add_sub_multiply_unit.sv
rtl/pasm_checker.sv
tb/sv/tb_polynomial_add_sub_multiply_unit.sv
